/* sv/lzbd_pkg.sv */
// Shared types, item codes and helpers for the MIO0 stream decoder.
`default_nettype none

package lzbd_pkg;

	localparam int unsigned WIN_DEPTH = 4096;
	localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);

	localparam logic [31:0] MIO0_MAGIC = 32'h4d49_4f30;
	localparam int unsigned LEN_SHIFT  = 12;
	localparam logic [4:0]  LEN_BIAS   = 5'd3;

	// Item kinds, as carried by opcode and need_next
	localparam logic [2:0] OP_MAGIC = 3'd0;
	localparam logic [2:0] OP_SIZE  = 3'd1;
	localparam logic [2:0] OP_CTRL  = 3'd2;
	localparam logic [2:0] OP_LIT   = 3'd3;
	localparam logic [2:0] OP_PAIR  = 3'd4;

	typedef enum logic [3:0] {
		PH_MAGIC = 4'b0001,
		PH_SIZE  = 4'b0010,
		PH_BODY  = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_COPY = 2'b10
	} seq_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       last_of_run;
		logic [2:0] need_next;
		logic       done_res;
		logic       error;
	} res_t;

	// Item kind the stream expects in a given phase
	function automatic logic [2:0] next_kind(phase_t ph, logic [5:0] bits, logic top);
		logic [2:0] k;
		begin
			k = OP_MAGIC;
			case (ph)
				PH_SIZE: k = OP_SIZE;
				PH_BODY: begin
					if (bits == 6'd0)
						k = OP_CTRL;
					else if (top)
						k = OP_LIT;
					else
						k = OP_PAIR;
				end
				default: k = OP_MAGIC;
			endcase
			return k;
		end
	endfunction

endpackage

`default_nettype wire

/* sv/lzbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzbd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* sv/lz_backref_decompressor.sv */
// MIO0 stream decoder: item sequencer, history window and result register.
// A result is registered as its item is accepted; the first byte of a copy comes
// behind the window read. Header, control, literal and rejected items are taken
// while the sequencer is idle and the output is free; a copy of up to 18 bytes, cut
// short at the declared size, holds off items while the single window read port feeds it.
// Reset clears the sequencer state and counters; window contents stay undefined.
`default_nettype none

module lz_backref_decompressor
	import lzbd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_t       res
);

	seq_t                st_q, st_d;
	phase_t              phase_q, phase_d;
	logic [WIN_AW-1:0]   wp_q, wp_d;
	logic [WIN_AW:0]     written_q, written_d;   // saturates at the window depth
	logic [31:0]         rem_q, rem_d;
	logic [31:0]         ctrl_q, ctrl_d;
	logic [5:0]          bits_q, bits_d;
	logic [WIN_AW-1:0]   src_q, src_d;
	logic [4:0]          cnt_q, cnt_d;
	logic                dist1_q, dist1_d;
	logic [2:0]          nn_q, nn_d;
	logic                dn_q, dn_d;
	logic [7:0]          last_q, last_d;
	logic                res_valid_q;
	res_t                res_q, res_d;
	logic                load;

	logic                ofree, accept, emit;
	logic [2:0]          exp_kind;
	logic [5:0]          bits_dec;
	logic [31:0]         ctrl_shl;
	logic [WIN_AW:0]     back_dist;
	logic [4:0]          count;
	logic                done_will;
	logic [WIN_AW-1:0]   rd_addr;
	logic                rd_en;
	logic [7:0]          rd_data;
	logic                wr_en;
	logic [7:0]          wr_data;
	logic [7:0]          copy_byte;

	assign ofree      = !res_valid_q || !res_stall;
	assign item_stall = !((st_q == ST_IDLE) && ofree);
	assign accept     = item_valid && !item_stall;
	assign emit       = (st_q == ST_COPY) && ofree;

	assign exp_kind  = next_kind(phase_q, bits_q, ctrl_q[31]);
	assign bits_dec  = bits_q - 6'd1;
	assign ctrl_shl  = {ctrl_q[30:0], 1'b0};
	assign back_dist = {1'b0, item.value[WIN_AW-1:0]} + {{WIN_AW{1'b0}}, 1'b1};
	assign count     = {1'b0, item.value[LEN_SHIFT+3:LEN_SHIFT]} + LEN_BIAS;
	assign done_will = rem_q <= {27'd0, count};
	assign copy_byte = dist1_q ? last_q : rd_data;

	always_comb begin
		st_d      = st_q;
		phase_d   = phase_q;
		wp_d      = wp_q;
		written_d = written_q;
		rem_d     = rem_q;
		ctrl_d    = ctrl_q;
		bits_d    = bits_q;
		src_d     = src_q;
		cnt_d     = cnt_q;
		dist1_d   = dist1_q;
		nn_d      = nn_q;
		dn_d      = dn_q;
		last_d    = last_q;
		load      = 1'b0;
		res_d     = res_q;
		rd_en     = 1'b0;
		rd_addr   = src_q;
		wr_en     = 1'b0;
		wr_data   = item.value[7:0];

		if (accept) begin
			res_d = '{byte_valid: 1'b0, out_byte: 8'd0, last_of_run: 1'b1,
				need_next: OP_MAGIC, done_res: 1'b0, error: 1'b0};
			load  = 1'b1;
			if (item.opcode != exp_kind) begin
				res_d.error = 1'b1;
				phase_d     = PH_MAGIC;
			end else begin
				case (item.opcode)
					OP_MAGIC: begin
						if (item.value == MIO0_MAGIC) begin
							phase_d         = PH_SIZE;
							wp_d            = '0;
							written_d       = '0;
							rem_d           = '0;
							ctrl_d          = '0;
							bits_d          = '0;
							res_d.need_next = OP_SIZE;
						end else begin
							res_d.error = 1'b1;
							phase_d     = PH_MAGIC;
						end
					end
					OP_SIZE: begin
						rem_d     = item.value;
						written_d = '0;
						bits_d    = '0;
						if (item.value == 32'd0) begin
							phase_d        = PH_DONE;
							res_d.done_res = 1'b1;
						end else begin
							phase_d         = PH_BODY;
							res_d.need_next = OP_CTRL;
						end
					end
					OP_CTRL: begin
						ctrl_d          = item.value;
						bits_d          = 6'd32;
						res_d.need_next = item.value[31] ? OP_LIT : OP_PAIR;
					end
					OP_LIT: begin
						ctrl_d           = ctrl_shl;
						bits_d           = bits_dec;
						wr_en            = 1'b1;
						wp_d             = wp_q + 1'b1;
						written_d        = written_q + {{WIN_AW{1'b0}}, !written_q[WIN_AW]};
						rem_d            = rem_q - 32'd1;
						last_d           = item.value[7:0];
						res_d.byte_valid = 1'b1;
						res_d.out_byte   = item.value[7:0];
						if (rem_q == 32'd1) begin
							phase_d        = PH_DONE;
							res_d.done_res = 1'b1;
						end else begin
							res_d.need_next = next_kind(PH_BODY, bits_dec, ctrl_q[30]);
						end
					end
					OP_PAIR: begin
						ctrl_d = ctrl_shl;
						bits_d = bits_dec;
						if (back_dist > written_q) begin
							res_d.error = 1'b1;
							phase_d     = PH_MAGIC;
						end else begin
							// Start the copy: fetch the first source byte now
							load    = 1'b0;
							st_d    = ST_COPY;
							rd_en   = 1'b1;
							rd_addr = wp_q - back_dist[WIN_AW-1:0];
							src_d   = rd_addr + 1'b1;
							cnt_d   = count;
							dist1_d = (back_dist == {{WIN_AW{1'b0}}, 1'b1});
							dn_d    = done_will;
							nn_d    = done_will ? OP_MAGIC
								: next_kind(PH_BODY, bits_dec, ctrl_q[30]);
							phase_d = done_will ? PH_DONE : PH_BODY;
						end
					end
					default: begin
						res_d.error = 1'b1;
						phase_d     = PH_MAGIC;
					end
				endcase
			end
		end else if (emit) begin
			// One byte a beat while the output is free; prefetch the next source while writing this one
			load      = 1'b1;
			wr_en     = 1'b1;
			wr_data   = copy_byte;
			rd_en     = 1'b1;
			rd_addr   = src_q;
			src_d     = src_q + 1'b1;
			wp_d      = wp_q + 1'b1;
			written_d = written_q + {{WIN_AW{1'b0}}, !written_q[WIN_AW]};
			rem_d     = rem_q - 32'd1;
			cnt_d     = cnt_q - 5'd1;
			last_d    = copy_byte;
			res_d     = '{byte_valid: 1'b1, out_byte: copy_byte,
				last_of_run: (cnt_q == 5'd1) || (rem_q == 32'd1),
				need_next: nn_q, done_res: dn_q, error: 1'b0};
			if (res_d.last_of_run)
				st_d = ST_IDLE;
		end
	end

	lzbd_ram #(
		.WIDTH (8),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= PH_MAGIC;
			wp_q        <= '0;
			written_q   <= '0;
			rem_q       <= '0;
			ctrl_q      <= '0;
			bits_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			phase_q   <= phase_d;
			wp_q      <= wp_d;
			written_q <= written_d;
			rem_q     <= rem_d;
			ctrl_q    <= ctrl_d;
			bits_q    <= bits_d;
			cnt_q     <= cnt_d;
			if (load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		src_q   <= src_d;
		dist1_q <= dist1_d;
		nn_q    <= nn_d;
		dn_q    <= dn_d;
		last_q  <= last_d;
		if (load)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_copy_has_history: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY) |-> (written_q != '0))
		else $error("copy running with an empty history");

	a_copy_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY) |-> (rem_q != 32'd0) && (cnt_q != 5'd0))
		else $error("copy running past its length or the declared size");

	a_copy_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res_d.last_of_run |=> (st_q == ST_IDLE) && res_valid)
		else $error("sequencer did not return to idle after the final byte");

	a_no_item_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY) |-> !accept && !wr_en || emit)
		else $error("item accepted or window written while copy is held");

endmodule

`default_nettype wire

/* sim/lz_backref_decompressor_tb.sv */
// Self-checking testbench for the MIO0 stream decoder, with its own decode model.
`timescale 1ns / 1ps

module lz_backref_decompressor_tb;
	import lzbd_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned PRINT_CAP    = 30;
	localparam int unsigned LONG_SIZE    = 4300;

	// Opcodes the block never asks for
	localparam logic [2:0] OP_RSV5 = 3'd5;
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item       = '0;
	logic  res_valid;
	logic  res_stall  = 1'b0;
	res_t  res;

	int idle_pct   = 0;
	int stall_pct  = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// Decode model state
	logic [7:0]  win_mem [WIN_DEPTH];
	logic [11:0] wr_ptr     = '0;
	logic [31:0] n_written  = '0;
	logic [31:0] n_left     = '0;
	logic [31:0] ctrl_bits  = '0;
	logic [5:0]  bits_avail = '0;
	phase_t      stage      = PH_MAGIC;
	res_t        due_results[$];

	lz_backref_decompressor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	always #5 clk = ~clk;

	function automatic logic [2:0] want_kind();
		if (stage == PH_SIZE)
			return OP_SIZE;
		if (stage == PH_BODY) begin
			if (bits_avail == 6'd0)
				return OP_CTRL;
			return ctrl_bits[31] ? OP_LIT : OP_PAIR;
		end
		return OP_MAGIC;
	endfunction

	task automatic shift_bit();
		ctrl_bits  = ctrl_bits << 1;
		bits_avail = bits_avail - 6'd1;
	endtask

	task automatic push_byte(input logic [7:0] b);
		win_mem[wr_ptr] = b;
		wr_ptr    = wr_ptr + 12'd1;
		n_written = n_written + 32'd1;
		n_left    = n_left - 32'd1;
		if (n_left == 32'd0)
			stage = PH_DONE;
	endtask

	// Work out the results of one accepted beat and queue them
	task automatic decode_item(input item_t it);
		logic [7:0]  outb[$];
		logic        bad;
		logic [2:0]  nk;
		logic [15:0] pr;
		logic [12:0] back_dist;
		logic [11:0] src;
		logic [7:0]  b;
		int          cnt;
		res_t        r;
		bad = 1'b0;
		if (it.opcode != want_kind()) begin
			bad   = 1'b1;
			stage = PH_MAGIC;
		end else begin
			case (it.opcode)
				OP_MAGIC: begin
					if (it.value == MIO0_MAGIC) begin
						stage      = PH_SIZE;
						wr_ptr     = '0;
						n_written  = '0;
						n_left     = '0;
						ctrl_bits  = '0;
						bits_avail = '0;
					end else begin
						bad   = 1'b1;
						stage = PH_MAGIC;
					end
				end
				OP_SIZE: begin
					n_left     = it.value;
					n_written  = '0;
					bits_avail = '0;
					stage      = (it.value == 32'd0) ? PH_DONE : PH_BODY;
				end
				OP_CTRL: begin
					ctrl_bits  = it.value;
					bits_avail = 6'd32;
				end
				OP_LIT: begin
					shift_bit();
					outb.push_back(it.value[7:0]);
					push_byte(it.value[7:0]);
				end
				OP_PAIR: begin
					pr        = it.value[15:0];
					back_dist = {1'b0, pr[11:0]} + 13'd1;
					shift_bit();
					if (back_dist > n_written) begin
						bad   = 1'b1;
						stage = PH_MAGIC;
					end else begin
						cnt = int'(pr[15:12]) + int'(LEN_BIAS);
						// copy a byte at a time so that overlapping copies repeat
						while (cnt > 0 && stage == PH_BODY) begin
							src = wr_ptr - back_dist[11:0];
							b   = win_mem[src];
							outb.push_back(b);
							push_byte(b);
							cnt--;
						end
					end
				end
				default: ;
			endcase
		end
		nk = want_kind();
		r.need_next = nk;
		r.done_res  = (stage == PH_DONE);
		r.error     = bad;
		if (outb.size() == 0) begin
			r.byte_valid  = 1'b0;
			r.out_byte    = 8'h00;
			r.last_of_run = 1'b1;
			due_results.push_back(r);
		end else begin
			foreach (outb[k]) begin
				r.byte_valid  = 1'b1;
				r.out_byte    = outb[k];
				r.last_of_run = (k == outb.size() - 1);
				due_results.push_back(r);
			end
		end
	endtask

	// Pick the next item from the model's state; mostly well formed, some noise
	function automatic item_t make_item(input bit dense, input int noise_pct);
		item_t       it;
		int          span;
		int          pick;
		logic [3:0]  len;
		logic [11:0] dm1;
		it.value = $urandom();
		if ($urandom_range(99) < noise_pct) begin
			it.opcode = 3'($urandom_range(7));
			if ($urandom_range(3) == 0)
				it.value = MIO0_MAGIC;
			return it;
		end
		it.opcode = want_kind();
		case (it.opcode)
			OP_MAGIC: it.value = MIO0_MAGIC;
			OP_SIZE: begin
				pick = $urandom_range(99);
				if (pick < 8)
					it.value = 32'd0;
				else if (pick < 12)
					it.value = $urandom();
				else if (pick < 25)
					it.value = $urandom_range(400, 65);
				else
					it.value = $urandom_range(64, 1);
			end
			OP_CTRL: begin
				if (dense)
					for (int i = 0; i < 32; i++)
						it.value[i] = ($urandom_range(7) == 0);
				// a pair cannot come first in a stream
				if (n_written == 32'd0)
					it.value[31] = 1'b1;
			end
			OP_PAIR: begin
				span = (n_written > WIN_DEPTH) ? WIN_DEPTH : int'(n_written);
				len  = dense ? 4'hF : 4'($urandom_range(15));
				pick = $urandom_range(99);
				if (span == 0)
					dm1 = 12'($urandom());
				else if (!dense && pick < 4 && span < WIN_DEPTH)
					dm1 = 12'(span);
				else if (pick < 45)
					dm1 = 12'($urandom_range(((span < 3) ? span : 3) - 1));
				else if (pick < 55)
					dm1 = 12'(span - 1);
				else
					dm1 = 12'($urandom_range(span - 1));
				it.value[15:0] = {len, dm1};
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		decode_item(it);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		idle_pct  = send_pct;
		stall_pct = recv_pct;
	endtask

	// Hold the sender off until every queued result has come back
	task automatic pause_until_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= PRINT_CAP)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		res_t want_r;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= PRINT_CAP)
					$display("%0t: unexpected result: expected none, got %0h", $time, res);
			end else begin
				want_r = due_results.pop_front();
				check_field("byte_valid",  want_r.byte_valid,  res.byte_valid);
				check_field("out_byte",    want_r.out_byte,    res.out_byte);
				check_field("last_of_run", want_r.last_of_run, res.last_of_run);
				check_field("need_next",   want_r.need_next,   res.need_next);
				check_field("done_res",    want_r.done_res,    res.done_res);
				check_field("error",       want_r.error,       res.error);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic test_header_checks();
		set_idling(0, 0);
		send_item('{OP_SIZE, 32'd5});
		send_item('{OP_MAGIC, 32'h4d49_4f31});
		send_item('{OP_RSV7, 32'hFFFF_FFFF});
		send_item('{OP_RSV5, 32'h0000_0000});
		send_item('{OP_MAGIC, MIO0_MAGIC});
		send_item('{OP_SIZE, 32'd0});
		// a literal after done is rejected; the stream then waits for a new magic word
		send_item('{OP_LIT, 32'h0000_00AA});
	endtask

	task automatic test_copy_cases();
		set_idling(0, 0);
		// overlapping full-length copy, cut short at the declared size
		send_item('{OP_MAGIC, MIO0_MAGIC});
		send_item('{OP_SIZE, 32'd10});
		send_item('{OP_CTRL, 32'hC000_0000});
		send_item('{OP_LIT, 32'hFFFF_FF00});
		send_item('{OP_LIT, 32'h0000_00FF});
		send_item('{OP_PAIR, 32'hFFFF_F000});
		// distance reaching before the first byte
		send_item('{OP_MAGIC, MIO0_MAGIC});
		send_item('{OP_SIZE, 32'd4});
		send_item('{OP_CTRL, 32'h8000_0000});
		send_item('{OP_LIT, 32'h1234_565A});
		send_item('{OP_PAIR, 32'h0000_0001});
		send_item('{OP_RSV6, 32'h0000_0000});
		// exact finish on a copy
		send_item('{OP_MAGIC, MIO0_MAGIC});
		send_item('{OP_SIZE, 32'd4});
		send_item('{OP_CTRL, 32'hBFFF_FFFF});
		send_item('{OP_LIT, 32'h0000_0033});
		send_item('{OP_PAIR, 32'h0000_0000});
	endtask

	// Long stream that wraps the window and copies from the full distance
	task automatic test_long_window();
		set_idling(19, 19);
		send_item('{OP_MAGIC, MIO0_MAGIC});
		send_item('{OP_SIZE, LONG_SIZE});
		while (want_kind() != OP_MAGIC)
			send_item(make_item(1'b1, 0));
	endtask

	task automatic test_random_streams();
		int send_pct[4] = '{0, 60, 0, 19};
		int recv_pct[4] = '{0, 0, 60, 19};
		for (int p = 0; p < 4; p++) begin
			set_idling(send_pct[p], recv_pct[p]);
			repeat (45)
				send_item(make_item(1'b0, 8));
			pause_until_drained();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_checks();
		test_copy_cases();
		pause_until_drained();
		test_long_window();
		pause_until_drained();
		test_random_streams();
		set_idling(0, 0);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
sv/lzbd_pkg.sv
sv/lzbd_ram.sv
sv/lz_backref_decompressor.sv
sim/lz_backref_decompressor_tb.sv
